/* sv/date_text_to_packed_timestamp_defines.svh */
// Assertion helpers for the date text parser.
`ifndef DATE_TEXT_TO_PACKED_TIMESTAMP_DEFINES_SVH
`define DATE_TEXT_TO_PACKED_TIMESTAMP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DTPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DTPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/dtpt_pkg.sv */
package dtpt_pkg;

  localparam int unsigned NumMonths = 12;

  // Month codes, three upper-case letters each; July is spelled JLY.
  localparam logic [23:0] MonthCodes [NumMonths] = '{
    "JAN", "FEB", "MAR", "APR", "MAY", "JUN",
    "JLY", "AUG", "SEP", "OCT", "NOV", "DEC"
  };

  // Characters
  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChColon = 8'h3A;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoZ   = 8'h7A;
  localparam logic [7:0] CaseGap = 8'h20;

  // Number accumulator ceiling
  localparam logic [30:0] NumMax = 31'h7FFF_FFFF;

  // Eight-digit yyyymmdd window
  localparam logic [30:0] EightLow  = 31'd19000000;
  localparam logic [30:0] EightHigh = 31'd21000000;

  // Two-digit year windowing
  localparam logic [30:0] WinOldLow  = 31'd60;
  localparam logic [30:0] WinOldHigh = 31'd99;
  localparam logic [30:0] WinNewHigh = 31'd20;
  localparam logic [31:0] Century19  = 32'd1900;
  localparam logic [31:0] Century20  = 32'd2000;
  localparam logic [31:0] DosEpoch   = 32'd1980;

  // Months (zero based) that take one off the hour
  localparam logic [31:0] DstFirst = 32'd5;
  localparam logic [31:0] DstLast  = 32'd8;

  // Bits of the found mask
  localparam int unsigned BitSec   = 0;
  localparam int unsigned BitMin   = 1;
  localparam int unsigned BitHour  = 2;
  localparam int unsigned BitDay   = 3;
  localparam int unsigned BitMonth = 4;
  localparam int unsigned BitYear  = 5;

  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || (c inside {[ChTab:ChCr]});
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c inside {[ChUpA:ChUpZ]}) || (c inside {[ChLoA:ChLoZ]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[ChZero:ChNine]};
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c inside {[ChLoA:ChLoZ]}) ? c - CaseGap : c;
  endfunction

  // Quotient by 100 for values below 1000: multiply by 41/4096.
  function automatic logic [3:0] div100(input logic [9:0] x);
    logic [15:0] p;
    p = {6'b0, x} * 16'd41;
    return p[15:12];
  endfunction

endpackage

/* sv/date_text_to_packed_timestamp.sv */
// End of string: the input, field-capture and output registers form the path.
// Throughput: one byte per cycle unless an end byte stalls for the capture stage;
// a result may wait in the output register while bytes keep flowing.
// Reset: rst_ni clears the parser state and all valid flags asynchronously.
`include "date_text_to_packed_timestamp_defines.svh"

module date_text_to_packed_timestamp (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        is_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] packed_time_o,
  output logic [5:0]  fields_found_o
);

  import dtpt_pkg::*;

  typedef enum logic [1:0] {
    PH_BETWEEN = 2'd0,
    PH_LETTERS = 2'd1,
    PH_DIGITS  = 2'd2
  } phase_e;

  typedef struct packed {
    logic [31:0] year;
    logic [31:0] month;
    logic [30:0] day;
    logic [30:0] hour;
    logic [30:0] minute;
    logic [30:0] second;
    logic [5:0]  found;
  } fields_t;

  // Handshake
  logic in_vq, pk_vq, out_vq;
  logic out_rdy, pk_rdy, in_go, in_rdy;

  // Input register
  logic [7:0] in_byte_q;
  logic       in_end_q;

  // Parser state
  phase_e      phase_q;
  logic [7:0]  let_q [3];
  logic [1:0]  let_cnt_q;
  logic [30:0] num_q;
  logic [6:0]  lo_q, hi_q;
  logic [11:0] yq_q;
  logic [7:0]  sep_q;
  fields_t     fld_q;

  // Capture and output registers
  fields_t     pk_q;
  logic [31:0] packed_q;
  logic [5:0]  found_q;

  assign out_rdy = !out_vq || !out_stall_i;
  assign pk_rdy  = !pk_vq || out_rdy;
  assign in_go   = in_vq && (!in_end_q || pk_rdy);
  assign in_rdy  = !in_vq || in_go;

  assign in_stall_o     = !in_rdy;
  assign out_valid_o    = out_vq;
  assign packed_time_o  = packed_q;
  assign fields_found_o = found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (in_rdy) begin
      in_vq <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && in_valid_i) begin
      in_byte_q <= text_byte_i;
      in_end_q  <= is_end_i || (text_byte_i == ChNul);
    end
  end

  // Byte classes and arithmetic for the current byte
  logic [7:0]  ender;
  logic        c_alpha, c_digit, c_space;
  logic [3:0]  digit;
  logic [34:0] prod;
  logic [30:0] num_acc;
  logic [9:0]  t1, t2, r1, r2;
  logic [3:0]  c1, c2;
  logic [6:0]  lo_n, hi_n;
  logic [11:0] yq_n;
  logic        mhit;
  logic [3:0]  midx;
  logic        do_let, do_num, eight, slash_form;
  logic [31:0] yv;
  fields_t     fin;

  assign ender   = in_end_q ? ChNul : in_byte_q;
  assign c_alpha = is_alpha(in_byte_q);
  assign c_digit = is_digit(in_byte_q);
  assign c_space = is_space(in_byte_q);
  assign digit   = in_byte_q[3:0];

  // Saturating times-ten accumulate
  assign prod    = ({4'b0, num_q} << 3) + ({4'b0, num_q} << 1) + {31'b0, digit};
  assign num_acc = (prod > {4'b0, NumMax}) ? NumMax : prod[30:0];

  // Track the value split as yyyy | mm | dd alongside the accumulator
  assign t1   = {3'b0, lo_q} * 10'd10 + {6'b0, digit};
  assign c1   = div100(t1);
  assign r1   = t1 - {6'b0, c1} * 10'd100;
  assign lo_n = r1[6:0];
  assign t2   = {3'b0, hi_q} * 10'd10 + {6'b0, c1};
  assign c2   = div100(t2);
  assign r2   = t2 - {6'b0, c2} * 10'd100;
  assign hi_n = r2[6:0];
  assign yq_n = yq_q * 12'd10 + {8'b0, c2};

  always_comb begin
    mhit = 1'b0;
    midx = '0;
    for (int m = 0; m < NumMonths; m++) begin
      if (!mhit && {to_upper(let_q[0]), to_upper(let_q[1]), to_upper(let_q[2])}
                   == MonthCodes[m]) begin
        mhit = 1'b1;
        midx = 4'(m);
      end
    end
  end

  assign do_let = (phase_q == PH_LETTERS) && (in_end_q || !c_alpha);
  assign do_num = (phase_q == PH_DIGITS) && (in_end_q || !c_digit);
  assign eight  = (fld_q.found == '0)
                  && (ender == ChSlash || ender == ChNul || ender == ChColon)
                  && (num_q >= EightLow) && (num_q <= EightHigh);
  assign slash_form = (ender == ChSlash) || (ender == ChNul && sep_q == ChSlash);

  always_comb begin
    if (num_q >= WinOldLow && num_q <= WinOldHigh) begin
      yv = {1'b0, num_q} + Century19;
    end else if (num_q <= WinNewHigh) begin
      yv = {1'b0, num_q} + Century20;
    end else begin
      yv = {1'b0, num_q};
    end
  end

  // Field values after the token ending at this byte is finished
  always_comb begin
    fin = fld_q;
    if (do_let) begin
      if (let_cnt_q == 2'd3 && mhit) begin
        fin.found[BitMonth] = 1'b1;
        fin.month           = {28'b0, midx};
      end
    end else if (do_num) begin
      if (eight) begin
        fin.found[BitYear]  = 1'b1;
        fin.found[BitMonth] = 1'b1;
        fin.found[BitDay]   = 1'b1;
        fin.year            = {20'b0, yq_q} - DosEpoch;
        fin.month           = {25'b0, hi_q} - 32'd1;
        fin.day             = {24'b0, lo_q};
      end else if (slash_form) begin
        if (fld_q.found == '0) begin
          fin.found[BitYear] = 1'b1;
          fin.year           = yv - DosEpoch;
        end else if (!fld_q.found[BitMonth]) begin
          fin.found[BitMonth] = 1'b1;
          fin.month           = {1'b0, num_q} - 32'd1;
        end else if (!fld_q.found[BitDay]) begin
          fin.found[BitDay] = 1'b1;
          fin.day           = num_q;
        end
      end else if (ender == ChColon) begin
        if (!fld_q.found[BitDay]) begin
          fin.found[BitDay] = 1'b1;
          fin.day           = num_q;
        end else if (!fld_q.found[BitHour]) begin
          fin.found[BitHour] = 1'b1;
          fin.hour           = num_q;
        end else if (!fld_q.found[BitMin]) begin
          fin.found[BitMin] = 1'b1;
          fin.minute        = num_q;
        end else begin
          fin.found[BitSec] = 1'b1;
          fin.second        = num_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_BETWEEN;
      let_q[0]  <= '0;
      let_q[1]  <= '0;
      let_q[2]  <= '0;
      let_cnt_q <= '0;
      num_q     <= '0;
      lo_q      <= '0;
      hi_q      <= '0;
      yq_q      <= '0;
      sep_q     <= '0;
      fld_q     <= '0;
    end else if (in_go) begin
      if (in_end_q) begin
        // Result leaves through the capture register; start a fresh string
        phase_q   <= PH_BETWEEN;
        let_q[0]  <= '0;
        let_q[1]  <= '0;
        let_q[2]  <= '0;
        let_cnt_q <= '0;
        num_q     <= '0;
        lo_q      <= '0;
        hi_q      <= '0;
        yq_q      <= '0;
        sep_q     <= '0;
        fld_q     <= '0;
      end else begin
        case (phase_q)
          PH_LETTERS: begin
            if (c_alpha) begin
              if (let_cnt_q != 2'd3) begin
                let_q[let_cnt_q] <= in_byte_q;
                let_cnt_q        <= let_cnt_q + 2'd1;
              end
            end else begin
              fld_q   <= fin;
              sep_q   <= in_byte_q;
              phase_q <= PH_BETWEEN;
            end
          end
          PH_DIGITS: begin
            if (c_digit) begin
              num_q <= num_acc;
              lo_q  <= lo_n;
              hi_q  <= hi_n;
              yq_q  <= yq_n;
            end else begin
              fld_q   <= fin;
              sep_q   <= in_byte_q;
              phase_q <= PH_BETWEEN;
            end
          end
          default: begin
            if (c_space) begin
              phase_q <= PH_BETWEEN;
            end else if (c_alpha) begin
              phase_q   <= PH_LETTERS;
              let_q[0]  <= in_byte_q;
              let_cnt_q <= 2'd1;
            end else if (c_digit) begin
              phase_q <= PH_DIGITS;
              num_q   <= {27'b0, digit};
              lo_q    <= {3'b0, digit};
              hi_q    <= '0;
              yq_q    <= '0;
            end else begin
              // Stray byte: take it as the separator
              sep_q   <= in_byte_q;
              phase_q <= PH_BETWEEN;
            end
          end
        endcase
      end
    end
  end

  // Capture stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pk_vq <= 1'b0;
    end else if (pk_rdy) begin
      pk_vq <= in_go && in_end_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pk_rdy && in_go && in_end_q) begin
      pk_q <= fin;
    end
  end

  // Packing
  logic        dst;
  logic [31:0] date_w, time_w, packed_d;

  assign dst      = (pk_q.month >= DstFirst) && (pk_q.month <= DstLast);
  assign date_w   = (pk_q.year << 9) + ((pk_q.month + 32'd1) << 5) + {1'b0, pk_q.day};
  assign time_w   = (({1'b0, pk_q.hour} - {31'b0, dst}) << 11)
                    + ({1'b0, pk_q.minute} << 5) + {2'b0, pk_q.second[30:1]};
  assign packed_d = (date_w << 16) + time_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else if (out_rdy) begin
      out_vq <= pk_vq;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && pk_vq) begin
      packed_q <= packed_d;
      found_q  <= pk_q.found;
    end
  end

  `DTPT_ASSERT_NOW(a_letters_count, phase_q == PH_LETTERS, let_cnt_q != 2'd0,
                   "letter token with no letters stored")
  `DTPT_ASSERT_NEXT(a_end_clears, in_go && in_end_q,
                    phase_q == PH_BETWEEN && fld_q.found == 6'd0,
                    "parser state not cleared after end of string")
  `DTPT_ASSERT_NEXT(a_capture_moves, pk_vq && out_rdy, out_vq,
                    "captured fields did not reach the output register")

endmodule

/* tb/date_text_to_packed_timestamp_tb.sv */
`timescale 1ns / 1ps

import dtpt_pkg::*;

localparam string MonthText = "JANFEBMARAPRMAYJUNJLYAUGSEPOCTNOVDEC";

typedef enum logic [1:0] {PARSE_GAP, PARSE_WORD, PARSE_NUMBER} parse_phase_e;

typedef struct packed {
  logic [31:0] stamp;
  logic [5:0]  fields;
} timestamp_result_t;

typedef struct packed {
  logic [7:0] ch;
  logic       term;
} text_request_t;

class timestamp_scoreboard;
  parse_phase_e      phase;
  logic [7:0]        word [3];
  int unsigned       word_len;
  logic [30:0]       num_acc;
  logic [7:0]        last_sep;
  logic [5:0]        found;
  logic [31:0]       year_ofs, month, day, hour, minute, second;
  timestamp_result_t pending_q[$];
  int unsigned       mismatch_count;
  int unsigned       checked_count;
  int unsigned       accepted_count;

  function new();
    clear_fields();
    mismatch_count = 0;
    checked_count  = 0;
    accepted_count = 0;
  endfunction

  function void clear_fields();
    phase    = PARSE_GAP;
    word[0]  = '0;
    word[1]  = '0;
    word[2]  = '0;
    word_len = 0;
    num_acc  = '0;
    last_sep = '0;
    found    = '0;
    year_ofs = '0;
    month    = '0;
    day      = '0;
    hour     = '0;
    minute   = '0;
    second   = '0;
  endfunction

  function bit is_blank(logic [7:0] c);
    return c == ChSpace || (c >= ChTab && c <= ChCr);
  endfunction

  function bit is_letter(logic [7:0] c);
    return (c >= ChUpA && c <= ChUpZ) || (c >= ChLoA && c <= ChLoZ);
  endfunction

  function bit is_numeral(logic [7:0] c);
    return c >= ChZero && c <= ChNine;
  endfunction

  function logic [7:0] fold_upper(logic [7:0] c);
    return (c >= ChLoA && c <= ChLoZ) ? c - CaseGap : c;
  endfunction

  function void close_word();
    int m;
    if (word_len < 3) return;
    for (m = 0; m < 12; m++) begin
      if (fold_upper(word[0]) == MonthText[m*3] &&
          fold_upper(word[1]) == MonthText[m*3+1] &&
          fold_upper(word[2]) == MonthText[m*3+2]) begin
        found[BitMonth] = 1'b1;
        month = m;
        return;
      end
    end
  endfunction

  function void close_number(logic [7:0] ender);
    logic [31:0] v, y, rest, mo;
    v = {1'b0, num_acc};
    if (found == '0 && (ender == ChSlash || ender == ChNul || ender == ChColon) &&
        v >= EightLow && v <= EightHigh) begin
      y    = v / 10000;
      rest = v - y * 10000;
      mo   = rest / 100;
      found[BitYear]  = 1'b1;
      found[BitMonth] = 1'b1;
      found[BitDay]   = 1'b1;
      year_ofs = y - DosEpoch;
      month    = mo - 1;
      day      = rest - mo * 100;
    end else if (ender == ChSlash || (ender == ChNul && last_sep == ChSlash)) begin
      if (found == '0) begin
        found[BitYear] = 1'b1;
        // window two-digit years
        if (v >= WinOldLow && v <= WinOldHigh) v = v + Century19;
        else if (v <= WinNewHigh) v = v + Century20;
        year_ofs = v - DosEpoch;
      end else if (!found[BitMonth]) begin
        found[BitMonth] = 1'b1;
        month = v - 1;
      end else if (!found[BitDay]) begin
        found[BitDay] = 1'b1;
        day = v;
      end
    end else if (ender == ChColon) begin
      if (!found[BitDay]) begin
        found[BitDay] = 1'b1;
        day = v;
      end else if (!found[BitHour]) begin
        found[BitHour] = 1'b1;
        hour = v;
      end else if (!found[BitMin]) begin
        found[BitMin] = 1'b1;
        minute = v;
      end else begin
        found[BitSec] = 1'b1;
        second = v;
      end
    end
  endfunction

  function void note_request(logic [7:0] b, logic e);
    timestamp_result_t r;
    logic [31:0]       summer, date_word, time_word;
    logic [63:0]       grown;
    accepted_count++;
    if (e || b == ChNul) begin
      if (phase == PARSE_WORD) close_word();
      else if (phase == PARSE_NUMBER) close_number(ChNul);
      summer    = (month >= DstFirst && month <= DstLast) ? 32'd1 : 32'd0;
      date_word = (year_ofs << 9) + ((month + 32'd1) << 5) + day;
      time_word = ((hour - summer) << 11) + (minute << 5) + (second >> 1);
      r.stamp   = (date_word << 16) + time_word;
      r.fields  = found;
      pending_q.push_back(r);
      clear_fields();
      return;
    end
    case (phase)
      PARSE_WORD: begin
        if (is_letter(b)) begin
          if (word_len < 3) begin
            word[word_len] = b;
            word_len++;
          end
        end else begin
          // the ender is consumed, even a digit
          close_word();
          last_sep = b;
          phase    = PARSE_GAP;
        end
      end
      PARSE_NUMBER: begin
        if (is_numeral(b)) begin
          grown   = {33'd0, num_acc} * 64'd10 + {56'd0, b - ChZero};
          num_acc = (grown > {33'd0, NumMax}) ? NumMax : grown[30:0];
        end else begin
          close_number(b);
          last_sep = b;
          phase    = PARSE_GAP;
        end
      end
      default: begin
        if (is_blank(b)) begin
        end else if (is_letter(b)) begin
          phase    = PARSE_WORD;
          word[0]  = b;
          word_len = 1;
        end else if (is_numeral(b)) begin
          phase   = PARSE_NUMBER;
          num_acc = 31'(b - ChZero);
        end else begin
          last_sep = b;
          phase    = PARSE_GAP;
        end
      end
    endcase
  endfunction

  task report_mismatch(string msg);
    $display("MISMATCH: %s", msg);
    mismatch_count++;
  endtask

  task check_result(logic [31:0] stamp, logic [5:0] fields);
    timestamp_result_t want;
    if (pending_q.size() == 0) begin
      report_mismatch($sformatf("timestamp %h fields %h with none pending", stamp, fields));
      return;
    end
    want = pending_q.pop_front();
    checked_count++;
    if (stamp !== want.stamp)
      report_mismatch($sformatf("result %0d packed_time %h, want %h",
                                checked_count, stamp, want.stamp));
    if (fields !== want.fields)
      report_mismatch($sformatf("result %0d fields_found %h, want %h",
                                checked_count, fields, want.fields));
  endtask
endclass

module date_text_to_packed_timestamp_tb;

  localparam int unsigned RandomItems = 1000;
  localparam int unsigned HoldCycles  = 500;
  localparam int unsigned CycleLimit  = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  text_byte_i;
  logic        is_end_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] packed_time_o;
  logic [5:0]  fields_found_o;

  timestamp_scoreboard sb;
  text_request_t       line_q[$];
  int unsigned         bytes_sent = 0;
  int unsigned         line_count = 0;
  int unsigned         cycle_count = 0;
  bit                  hold_req = 1'b0;
  bit                  hold_active = 1'b0;
  int unsigned         rx_wait;
  bit                  rx_fast;

  date_text_to_packed_timestamp i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .text_byte_i    (text_byte_i),
    .is_end_i       (is_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .packed_time_o  (packed_time_o),
    .fields_found_o (fields_found_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task push_char(logic [7:0] b);
    line_q.push_back('{ch: b, term: 1'b0});
  endtask

  task push_end(logic [7:0] b, logic e);
    line_q.push_back('{ch: b, term: e});
  endtask

  task push_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task push_decimal(longint unsigned v);
    push_text($sformatf("%0d", v));
  endtask

  task push_blank();
    if ($urandom_range(0, 2) == 0) push_char(8'($urandom_range(ChTab, ChCr)));
    else push_char(ChSpace);
  endtask

  function automatic logic [7:0] random_letter();
    return (ChUpA + 8'($urandom_range(0, 25))) | ($urandom_range(0, 1) ? CaseGap : 8'h00);
  endfunction

  task push_word();
    int         m, i, extra;
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) begin
      extra = $urandom_range(1, 5);
      for (i = 0; i < extra; i++) push_char(random_letter());
    end else begin
      m = $urandom_range(0, 11);
      for (i = 0; i < 3; i++) begin
        c = MonthText[m*3+i];
        if ($urandom_range(0, 1)) c = c | CaseGap;
        push_char(c);
      end
      extra = $urandom_range(0, 2);
      for (i = 0; i < extra; i++) push_char(random_letter());
    end
  endtask

  task push_time(int n);
    int i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) push_decimal($urandom_range(0, 65535));
      else push_decimal($urandom_range(0, 99));
      if ($urandom_range(0, 7) == 0) push_char(8'($urandom_range(1, 255)));
      else push_char(ChColon);
      if ($urandom_range(0, 5) == 0) push_blank();
    end
  endtask

  task push_random_end();
    if ($urandom_range(0, 1)) push_end(8'($urandom_range(0, 255)), 1'b1);
    else push_end(ChNul, 1'b0);
  endtask

  task build_random_line();
    logic [7:0] seps [5];
    int         n, i;
    seps = '{ChSlash, ChColon, ChSpace, 8'h2D, 8'h2C};
    case ($urandom_range(0, 9))
      0, 1: begin
        if ($urandom_range(0, 4) == 0) push_decimal($urandom_range(18999990, 21000010));
        else push_decimal($urandom_range(19000000, 21000000));
        if ($urandom_range(0, 1)) begin
          push_char(seps[$urandom_range(0, 2)]);
          push_time($urandom_range(1, 4));
        end
      end
      2, 3: begin
        case ($urandom_range(0, 2))
          0: push_decimal($urandom_range(0, 120));
          1: push_decimal($urandom_range(1980, 2107));
          default: push_decimal($urandom_range(0, 9999));
        endcase
        push_char(ChSlash);
        push_decimal($urandom_range(0, 13));
        push_char(ChSlash);
        push_decimal($urandom_range(0, 31));
        case ($urandom_range(0, 2))
          0: push_char(ChSlash);
          1: begin
            push_blank();
            push_time($urandom_range(1, 4));
          end
          default: ;
        endcase
      end
      4: begin
        push_word();
        push_blank();
        push_decimal($urandom_range(1, 31));
        push_char(seps[$urandom_range(0, 4)]);
        push_decimal($urandom_range(0, 2107));
        if ($urandom_range(0, 1)) begin
          push_char(ChSlash);
          push_time($urandom_range(1, 4));
        end
      end
      5: push_time($urandom_range(2, 5));
      6: begin
        n = $urandom_range(1, 12);
        for (i = 0; i < n; i++) push_char(8'($urandom_range(0, 255)));
      end
      7: begin
        n = $urandom_range(9, 12);
        for (i = 0; i < n; i++) push_char(ChZero + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 2) != 0) push_char(seps[$urandom_range(0, 1)]);
      end
      default: begin
        n = $urandom_range(2, 6);
        for (i = 0; i < n; i++) begin
          case ($urandom_range(0, 3))
            0, 1: push_decimal($urandom_range(0, 9999));
            2: push_word();
            default: push_char(8'($urandom_range(33, 126)));
          endcase
          push_char(seps[$urandom_range(0, 4)]);
        end
      end
    endcase
    push_random_end();
  endtask

  // Enter at a falling edge; leave at the falling edge after acceptance.
  task drive_request(text_request_t r, int gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    text_byte_i <= r.ch;
    is_end_i    <= r.term;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(r.ch, r.term);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task send_line();
    bit fast;
    int gap;
    fast = ($urandom_range(0, 3) == 0);
    while (line_q.size() != 0) begin
      gap = (fast || hold_active) ? 0 : $urandom_range(0, 14);
      drive_request(line_q.pop_front(), gap);
    end
    line_count++;
  endtask

  // Drop valid so the last request is not taken again, then wait for results.
  task wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.pending_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    out_stall_i = 1'b0;
    rx_wait     = 0;
    rx_fast     = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        sb.check_result(packed_time_o, fields_found_o);
        if ($urandom_range(0, 7) == 0) rx_fast = !rx_fast;
        rx_wait = rx_fast ? 0 : $urandom_range(0, 14);
      end
      @(negedge clk_i);
      if (hold_active) begin
        out_stall_i <= 1'b1;
      end else if (rx_wait != 0) begin
        rx_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Hold the output off while the sender keeps going, so the block backs up.
  initial begin
    wait (hold_req);
    @(posedge clk_i);
    hold_active = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_active = 1'b0;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TIMEOUT after %0d cycles", cycle_count);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    sb          = new();
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    text_byte_i = '0;
    is_end_i    = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // month word ended by a digit, summer hour, colon chain up to seconds
    push_text("Jly7 1:2:3:4:");
    push_end(8'hFF, 1'b1);
    send_line();
    // eight-digit date ended by the string end
    push_text("19991231");
    push_end(ChNul, 1'b0);
    send_line();
    // saturated number taken as day, then a stray byte
    push_text("9999999999:#");
    push_end(8'h80, 1'b1);
    send_line();
    // windowed year, day closed by end after a slash
    push_text("99/1/2");
    push_end(ChNul, 1'b0);
    send_line();
    wait_drained();

    while (bytes_sent < RandomItems) begin
      if (line_count == 10) hold_req = 1'b1;
      if (line_count == 30) wait_drained();
      build_random_line();
      send_line();
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Ran %0d text bytes in %0d strings, %0d timestamps checked",
             sb.accepted_count, line_count, sb.checked_count);
    $display("Mix: yyyymmdd, slash and colon forms, month names, noise, long output hold");
    if (sb.mismatch_count == 0 && sb.pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
